[rtl/upc8_pkg.sv]
package upc8_pkg;

   localparam int unsigned DATA_BITS = 8;
   localparam int unsigned COUNT_BITS = 4;

   localparam logic [DATA_BITS-1:0] CRC_POLY = 8'h1D;
   localparam logic [DATA_BITS-1:0] CRC_INIT = 8'hFF;
   localparam logic [DATA_BITS-1:0] CRC_XOROUT = 8'hFF;
   localparam logic [DATA_BITS-1:0] CRC_MSB = 8'h80;

   localparam logic [COUNT_BITS-1:0] COUNT_START = 4'd0;
   localparam logic [COUNT_BITS-1:0] COUNT_PARITY = 4'd9;
   localparam logic [COUNT_BITS-1:0] COUNT_STOP = 4'd10;

   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_PARITY = 2'd2,
      KIND_STOP   = 2'd3
   } bit_kind_type;

   function automatic logic [DATA_BITS-1:0] crc_fold(input logic [DATA_BITS-1:0] crc,
                                                     input logic [DATA_BITS-1:0] value);
      logic [DATA_BITS-1:0] c;
      c = crc ^ value;
      for (int i = 0; i < DATA_BITS; i++) begin
         if ((c & CRC_MSB) != '0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

[rtl/uart_parity_crc8_frame_transmitter_core.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_data_byte[7:0], req_last_byte
// rsp_      out        rsp_valid/rsp_stall  rsp_line_bit, rsp_bit_kind[1:0],
//                                           rsp_crc_frame, rsp_run_end
//
// One result per cycle while no result is stalled, from a 4-bit bit counter over an 11-bit frame:
// 11 results per ordinary byte, 22 for a byte that ends the message.
// The next byte is taken in the cycle its predecessor's final bit is registered.
// Synchronous reset clears the sequencer and output valid; the CRC returns to 0xFF.
// A stalled result holds the sequencer; rsp_stall reaches req_stall in the same cycle.
module uart_parity_crc8_frame_transmitter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_line_bit,
   output logic [1:0] rsp_bit_kind,
   output logic       rsp_crc_frame,
   output logic       rsp_run_end
);
   import upc8_pkg::*;

   logic                  active_ff, active_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [DATA_BITS-1:0]  shift_ff, shift_in;
   logic                  parity_ff, parity_in;
   logic                  last_ff, last_in;
   logic                  crc_frame_ff, crc_frame_in;
   logic [DATA_BITS-1:0]  crc_ff, crc_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_line_bit_ff, rsp_line_bit_in;
   bit_kind_type          rsp_bit_kind_ff, rsp_bit_kind_in;
   logic                  rsp_crc_frame_ff, rsp_crc_frame_in;
   logic                  rsp_run_end_ff, rsp_run_end_in;

   logic                  advance;
   logic                  final_bit;
   logic                  accept;
   logic [DATA_BITS-1:0]  crc_byte;

   assign advance   = active_ff && (!rsp_valid_ff || !rsp_stall);
   assign final_bit = (count_ff == COUNT_STOP) && (crc_frame_ff || !last_ff);
   assign req_stall = active_ff && !(advance && final_bit);
   assign accept    = req_valid && !req_stall;
   assign crc_byte  = crc_ff ^ CRC_XOROUT;

   always_comb begin
      active_in        = active_ff;
      count_in         = count_ff;
      shift_in         = shift_ff;
      parity_in        = parity_ff;
      last_in          = last_ff;
      crc_frame_in     = crc_frame_ff;
      crc_in           = crc_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_line_bit_in  = rsp_line_bit_ff;
      rsp_bit_kind_in  = rsp_bit_kind_ff;
      rsp_crc_frame_in = rsp_crc_frame_ff;
      rsp_run_end_in   = rsp_run_end_ff;

      if (advance) begin
         rsp_valid_in     = 1'b1;
         rsp_crc_frame_in = crc_frame_ff;
         rsp_run_end_in   = 1'b0;
         count_in         = count_ff + 1'b1;
         case (count_ff)
            COUNT_START: begin
               rsp_line_bit_in = 1'b0;
               rsp_bit_kind_in = KIND_START;
            end
            COUNT_PARITY: begin
               rsp_line_bit_in = parity_ff;
               rsp_bit_kind_in = KIND_PARITY;
            end
            COUNT_STOP: begin
               rsp_line_bit_in = 1'b1;
               rsp_bit_kind_in = KIND_STOP;
               rsp_run_end_in  = final_bit;
               count_in        = COUNT_START;
               if (final_bit) begin
                  active_in = 1'b0;
               end else begin
                  // switch to the appended CRC frame
                  shift_in     = crc_byte;
                  parity_in    = ^crc_byte;
                  crc_frame_in = 1'b1;
                  crc_in       = CRC_INIT;
               end
            end
            default: begin
               rsp_line_bit_in = shift_ff[0];
               rsp_bit_kind_in = KIND_DATA;
               shift_in        = shift_ff >> 1;
            end
         endcase
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         active_in    = 1'b1;
         count_in     = COUNT_START;
         shift_in     = req_data_byte;
         parity_in    = ^req_data_byte;
         last_in      = req_last_byte;
         crc_frame_in = 1'b0;
         crc_in       = crc_fold(crc_ff, req_data_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         count_ff     <= COUNT_START;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff         <= shift_in;
      parity_ff        <= parity_in;
      last_ff          <= last_in;
      crc_frame_ff     <= crc_frame_in;
      rsp_line_bit_ff  <= rsp_line_bit_in;
      rsp_bit_kind_ff  <= rsp_bit_kind_in;
      rsp_crc_frame_ff <= rsp_crc_frame_in;
      rsp_run_end_ff   <= rsp_run_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_bit  = rsp_line_bit_ff;
   assign rsp_bit_kind  = rsp_bit_kind_ff;
   assign rsp_crc_frame = rsp_crc_frame_ff;
   assign rsp_run_end   = rsp_run_end_ff;

endmodule

[rtl/upc8_checker.sv]
module upc8_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_line_bit,
   input logic [1:0] rsp_bit_kind,
   input logic       rsp_crc_frame,
   input logic       rsp_run_end
);
   import upc8_pkg::*;

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_bit)
         && $stable(rsp_bit_kind) && $stable(rsp_crc_frame) && $stable(rsp_run_end))
      else $error("stalled result changed");

   // a fresh byte keeps the request side stalled for its frame
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken during a frame");

   a_framing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_bit_kind == KIND_START || rsp_bit_kind == KIND_STOP)
         |-> rsp_line_bit == (rsp_bit_kind == KIND_STOP))
      else $error("bad start or stop level");

   a_end_on_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_end |-> rsp_bit_kind == KIND_STOP)
      else $error("run end off a stop bit");

   a_crc_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crc_frame && rsp_bit_kind == KIND_STOP |-> rsp_run_end)
      else $error("crc frame does not end the run");

endmodule

bind uart_parity_crc8_frame_transmitter_core upc8_checker u_upc8_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_line_bit  (rsp_line_bit),
   .rsp_bit_kind  (rsp_bit_kind),
   .rsp_crc_frame (rsp_crc_frame),
   .rsp_run_end   (rsp_run_end)
);

[verif/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import upc8_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [3:0] gap;
      logic       hold;
   } tx_byte_type;

   typedef struct packed {
      logic         line_bit;
      bit_kind_type kind;
      logic         crc_frame;
      logic         run_end;
   } line_slot_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_line_bit;
   logic [1:0] rsp_bit_kind;
   logic       rsp_crc_frame;
   logic       rsp_run_end;

   tx_byte_type   tx_bytes[$];
   line_slot_type line_expect[$];
   logic [7:0]    msg_crc = CRC_INIT;

   bit req_took = 1'b0;
   bit rsp_took = 1'b0;
   int drv_wait = 0;
   int rsp_wait = 0;
   int error_count = 0;
   int checked_count = 0;
   int sent_count = 0;
   int message_count = 0;
   int crc_bit_count = 0;

   uart_parity_crc8_frame_transmitter_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_line_bit  (rsp_line_bit),
      .rsp_bit_kind  (rsp_bit_kind),
      .rsp_crc_frame (rsp_crc_frame),
      .rsp_run_end   (rsp_run_end)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] value);
      logic [7:0] r;
      logic       fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ value[i];
         r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   task automatic push_frame(input logic [7:0] value, input logic is_crc, input logic ends);
      line_expect.push_back('{1'b0, KIND_START, is_crc, 1'b0});
      for (int i = 0; i < 8; i++) begin
         line_expect.push_back('{value[i], KIND_DATA, is_crc, 1'b0});
      end
      line_expect.push_back('{^value, KIND_PARITY, is_crc, 1'b0});
      line_expect.push_back('{1'b1, KIND_STOP, is_crc, ends});
   endtask

   task automatic predict_byte(input logic [7:0] value, input logic last);
      msg_crc = crc_next(msg_crc, value);
      push_frame(value, 1'b0, !last);
      if (last) begin
         push_frame(msg_crc ^ CRC_XOROUT, 1'b1, 1'b1);
         msg_crc = CRC_INIT;
         message_count++;
      end
   endtask

   task automatic add_byte(input logic [7:0] value, input logic last, input int gap,
                           input logic hold);
      tx_byte_type t;
      t.data = value;
      t.last = last;
      t.gap = gap[3:0];
      t.hold = hold;
      tx_bytes.push_back(t);
   endtask

   // sample both channels, predict and check
   always @(posedge clock) begin
      line_slot_type want;
      line_slot_type got;
      req_took = !reset && req_valid && !req_stall;
      rsp_took = !reset && rsp_valid && !rsp_stall;
      if (req_took) begin
         predict_byte(req_data_byte, req_last_byte);
      end
      if (rsp_took) begin
         got = '{rsp_line_bit, bit_kind_type'(rsp_bit_kind), rsp_crc_frame, rsp_run_end};
         if (line_expect.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("unexpected transaction: line %b kind %0d crc %b end %b",
                        rsp_line_bit, rsp_bit_kind, rsp_crc_frame, rsp_run_end);
            end
         end else begin
            want = line_expect.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch at result %0d: expected %b/%0d/%b/%b got %b/%0d/%b/%b",
                           checked_count, want.line_bit, want.kind, want.crc_frame,
                           want.run_end, got.line_bit, got.kind, got.crc_frame,
                           got.run_end);
               end
            end
            if (want.crc_frame) begin
               crc_bit_count++;
            end
         end
         checked_count++;
      end
   end

   // sender: gap before each byte, optional hold until the line drains
   always @(negedge clock) begin
      logic next_valid;
      if (!reset) begin
         next_valid = req_valid;
         if (req_valid && req_took) begin
            void'(tx_bytes.pop_front());
            sent_count++;
            next_valid = 1'b0;
            if (tx_bytes.size() != 0) begin
               drv_wait = int'(tx_bytes[0].gap);
            end
         end
         if (!next_valid && tx_bytes.size() != 0) begin
            if (drv_wait != 0) begin
               drv_wait--;
            end else if (!tx_bytes[0].hold || line_expect.size() == 0) begin
               next_valid = 1'b1;
               req_data_byte <= tx_bytes[0].data;
               req_last_byte <= tx_bytes[0].last;
            end
         end
         req_valid <= next_valid;
      end
   end

   // receiver: fresh stall count after each transaction, calm stretches in between
   always @(negedge clock) begin
      if (rsp_took) begin
         rsp_wait = (((checked_count / 300) % 4) == 2) ? 0 : $urandom_range(0, 15);
      end
      if (rsp_wait != 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      int rnd_count;
      int msg_len;
      int pick;
      int gap;
      logic lst;

      add_byte(8'h00, 1'b1, 0, 1'b0);
      add_byte(8'hFF, 1'b1, 3, 1'b0);
      add_byte(8'h01, 1'b0, 0, 1'b0);
      add_byte(8'h80, 1'b0, 0, 1'b0);
      add_byte(8'h55, 1'b1, 7, 1'b0);
      add_byte(8'hAA, 1'b0, 15, 1'b0);
      add_byte(8'h0F, 1'b0, 0, 1'b0);
      add_byte(8'hF0, 1'b1, 1, 1'b0);
      for (int i = 0; i < 9; i++) begin
         add_byte(8'h31 + i[7:0], (i == 8), 0, (i == 0));
      end
      add_byte(8'hFF, 1'b0, 2, 1'b0);
      add_byte(8'hFF, 1'b1, 0, 1'b0);

      rnd_count = 0;
      while (rnd_count < 460) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            msg_len = $urandom_range(1, 8);
         end else if (pick < 9) begin
            msg_len = $urandom_range(9, 24);
         end else begin
            msg_len = 0;
         end
         if (msg_len == 0) begin
            for (int i = 0; i < 4; i++) begin
               lst = 1'($urandom_range(0, 1));
               add_byte(8'($urandom_range(0, 255)), lst, $urandom_range(0, 15), 1'b0);
               rnd_count++;
            end
         end else begin
            for (int i = 0; i < msg_len; i++) begin
               gap = (((rnd_count / 60) % 3) == 1) ? 0 : $urandom_range(0, 15);
               add_byte(8'($urandom_range(0, 255)), (i == msg_len - 1), gap,
                        ((rnd_count % 120) == 0));
               rnd_count++;
            end
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (tx_bytes.size() != 0 || line_expect.size() != 0) begin
         @(negedge clock);
      end
      repeat (40) @(negedge clock);
      if (line_expect.size() != 0) begin
         error_count++;
      end

      $display("sent %0d bytes in %0d messages, checked %0d line bits (%0d crc)",
               sent_count, message_count, checked_count, crc_bit_count);
      $display("mismatches: %0d", error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/upc8_pkg.sv
rtl/uart_parity_crc8_frame_transmitter_core.sv
rtl/upc8_checker.sv
verif/tb_top.sv
